[rtl/core/icmper_pkg.sv]
// constants and the one's-complement adder shared by the icmp echo responder files
package icmper_pkg;

	localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
	localparam logic [15:0] SUM_ALL_ONES      = 16'hffff;
	localparam logic [15:0] REPLY_HEADER_WORD = 16'h0000;
	localparam logic [2:0]  POSITION_LIMIT    = 3'd4;
	localparam logic [2:0]  POSITION_CHECKSUM = 3'd1;
	localparam logic [2:0]  POSITION_LAST_HDR = 3'd3;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, a} + {1'b0, b};
		u = {1'b0, t[15:0]} + {16'h0000, t[16]};
		return u[15:0];
	endfunction

endpackage

[rtl/core/icmp_echo_responder.sv]
// icmp echo responder top level: rewrites an echo request into its reply word by word
// One 16-bit message word is taken per item and one reply word comes out per item, at up to one
// item per clock while out_stall is low. An item passes an input register and then a result
// register before its reply word shows on the output. Word 0 of the reply is zero,
// word 1 is the incrementally updated checksum and later words pass unchanged; an odd final byte
// has its low byte cleared. keep is set on the final word only when the message was an echo
// request of at least 8 bytes whose one's-complement sum is all ones. destination_address is the
// request's source_address, and state returns to its reset values after each final word.
module icmp_echo_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] data_word,
	input  logic        final_word,
	input  logic        odd_tail,
	input  logic [31:0] source_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] reply_word,
	output logic        reply_final,
	output logic        reply_odd_tail,
	output logic        keep,
	output logic [31:0] destination_address
);
	import icmper_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        final_s1;
	logic        odd_s1;
	logic [31:0] addr_s1;

	logic        valid_s2;
	logic [15:0] word_s2;
	logic        final_s2;
	logic        odd_s2;
	logic        keep_s2;
	logic [31:0] addr_s2;

	logic [2:0]  position_q;
	logic [15:0] sum_q;
	logic        is_request_q;
	logic [7:0]  code_q;

	logic        adv_s1;
	logic        load_s1;
	logic        odd;
	logic [15:0] w;
	logic [15:0] sum;
	logic        is_request;
	logic [15:0] rw;
	logic        long_enough;
	logic        keep_now;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign load_s1  = !valid_s1 || adv_s1;
	assign in_stall = !load_s1;

	always_comb begin
		odd         = final_s1 && odd_s1;
		w           = odd ? {word_s1[15:8], 8'h00} : word_s1;
		sum         = ones_add(sum_q, w);
		is_request  = (position_q == 3'd0) ? (w[15:8] == ECHO_REQUEST_TYPE) : is_request_q;
		case (position_q)
			3'd0:              rw = REPLY_HEADER_WORD;
			POSITION_CHECKSUM: rw = ones_add(w, {ECHO_REQUEST_TYPE, code_q});
			default:           rw = w;
		endcase
		if (odd) begin
			rw = {rw[15:8], 8'h00};
		end
		long_enough = (position_q >= POSITION_LIMIT) || (position_q == POSITION_LAST_HDR && !odd);
		keep_now    = final_s1 && long_enough && is_request && (sum == SUM_ALL_ONES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			word_s1  <= data_word;
			final_s1 <= final_word;
			odd_s1   <= odd_tail;
			addr_s1  <= source_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= 3'd0;
			sum_q        <= 16'h0000;
			is_request_q <= 1'b0;
			code_q       <= 8'h00;
		end else if (adv_s1) begin
			if (final_s1) begin
				position_q   <= 3'd0;
				sum_q        <= 16'h0000;
				is_request_q <= 1'b0;
				code_q       <= 8'h00;
			end else begin
				sum_q        <= sum;
				is_request_q <= is_request;
				if (position_q == 3'd0) begin
					code_q <= w[7:0];
				end
				if (position_q < POSITION_LIMIT) begin
					position_q <= position_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s2  <= rw;
			final_s2 <= final_s1;
			odd_s2   <= odd;
			keep_s2  <= keep_now;
			addr_s2  <= addr_s1;
		end
	end

	assign out_valid           = valid_s2;
	assign reply_word          = word_s2;
	assign reply_final         = final_s2;
	assign reply_odd_tail      = odd_s2;
	assign keep                = keep_s2;
	assign destination_address = addr_s2;

endmodule

[rtl/core/icmp_echo_chk.sv]
// port-level checker for the icmp echo responder and its bind
module icmp_echo_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] reply_word,
	input logic        reply_final,
	input logic        reply_odd_tail,
	input logic        keep
);
	import icmper_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_keep_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && keep |-> reply_final)
		else $error("keep set on a non-final item");

	a_odd_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_odd_tail |-> reply_final && reply_word[7:0] == 8'h00)
		else $error("odd tail item malformed");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && reply_final ##1 out_valid |-> reply_word == REPLY_HEADER_WORD)
		else $error("first reply word not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reply_word) && $stable(keep))
		else $error("stalled result changed");

endmodule

bind icmp_echo_responder icmp_echo_chk u_icmp_echo_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reply_word     (reply_word),
	.reply_final    (reply_final),
	.reply_odd_tail (reply_odd_tail),
	.keep           (keep)
);
